### rtl/pcx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcx_pkg;

  localparam int DEF_MAX_COLUMNS = 640;
  localparam int DEF_MAX_ROWS    = 480;

  localparam logic [7:0] RUN_MARK   = 8'hC0;
  localparam logic [5:0] COUNT_MASK = 6'h3F;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam int          ADDR_W           = 3;
  localparam logic [2:0]  ADDR_LAST_COLUMN = 3'd0;
  localparam logic [2:0]  ADDR_LAST_ROW    = 3'd4;

  typedef struct packed {
    logic [7:0] index;
    logic [5:0] count;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/pcx_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pcx_front
  import pcx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] code_byte_i,
  output cmd_t            cmd_o,
  output logic            cmd_push_o
);

  logic       awaiting_q, awaiting_d;
  logic [5:0] count_q, count_d;

  always_comb begin
    awaiting_d  = awaiting_q;
    count_d     = count_q;
    cmd_push_o  = 1'b0;
    cmd_o.index = code_byte_i;
    cmd_o.count = 6'd1;
    if (take_i) begin
      if (awaiting_q) begin
        cmd_push_o  = 1'b1;
        cmd_o.count = count_q;
        awaiting_d  = 1'b0;
        count_d     = 6'd0;
      end else if ((code_byte_i & RUN_MARK) == RUN_MARK) begin
        awaiting_d = 1'b1;
        count_d    = code_byte_i[5:0] & COUNT_MASK;
      end else begin
        cmd_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      count_q    <= 6'd0;
    end else begin
      awaiting_q <= awaiting_d;
      count_q    <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/pcx_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module pcx_cmd_fifo
  import pcx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/pcx_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pcx_back
  import pcx_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [9:0] last_column_i,
  input  wire logic [8:0] last_row_i,
  input  wire cmd_t       cmd_i,
  input  wire logic       cmd_empty_i,
  output logic            cmd_pop_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [7:0]      pixel_index_o,
  output logic [9:0]      pixel_column_o,
  output logic [8:0]      pixel_row_o,
  output logic            run_last_o,
  output logic            row_end_o,
  output logic            image_end_o
);

  logic       busy_q, busy_d;
  logic [7:0] val_q, val_d;
  logic [5:0] rem_q, rem_d;
  logic [9:0] col_q, col_d;
  logic [8:0] row_q, row_d;
  logic       done_q, done_d;
  logic       out_valid_q, out_valid_d;

  logic [9:0] lc_eff;
  logic [8:0] lr_eff;
  logic       rend, iend, last, emit;

  assign lc_eff = (32'(last_column_i) > 32'(MAX_COLUMNS - 1)) ? 10'(MAX_COLUMNS - 1)
                                                              : last_column_i;
  assign lr_eff = (32'(last_row_i) > 32'(MAX_ROWS - 1)) ? 9'(MAX_ROWS - 1) : last_row_i;

  assign rend = (col_q >= lc_eff);
  assign iend = rend && (row_q >= lr_eff);
  assign last = (rem_q == 6'd1) || rend;
  assign emit = busy_q && (!out_valid_q || pop_i);

  assign cmd_pop_o = (!busy_q || (emit && last)) && !cmd_empty_i;
  assign empty_o   = !out_valid_q;

  always_comb begin
    busy_d      = busy_q;
    val_d       = val_q;
    rem_d       = rem_q;
    col_d       = col_q;
    row_d       = row_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      rem_d       = rem_q - 6'd1;
      if (last) begin
        busy_d = 1'b0;
      end
      if (iend) begin
        done_d = 1'b1;
      end else if (rend) begin
        col_d = 10'd0;
        row_d = row_q + 9'd1;
      end else begin
        col_d = col_q + 10'd1;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_pop_o) begin
      val_d  = cmd_i.index;
      rem_d  = cmd_i.count;
      busy_d = (cmd_i.count != 6'd0) && !done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= 6'd0;
      col_q       <= 10'd0;
      row_q       <= 9'd0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      col_q       <= col_d;
      row_q       <= row_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (emit) begin
      pixel_index_o  <= val_q;
      pixel_column_o <= col_q;
      pixel_row_o    <= row_q;
      run_last_o     <= last;
      row_end_o      <= rend;
      image_end_o    <= iend;
    end
  end

endmodule

`default_nettype wire

### rtl/pcx_rle_pixel_decoder.sv
// A literal byte's pixel passes the command queue, run registers and output registers.
// Throughput: one pixel per cycle from the emit unit while the result ports are popped;
// literal bytes then flow at one per cycle; a run holds the emit unit to its last pixel
// (sooner when cut at a row end) while the 2-word command queue fills.
// Reset: asynchronous, active low; clears the queue, position, run and done state and
// sets both picture size registers to zero. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pcx_rle_pixel_decoder
  import pcx_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic [7:0]        code_byte_i,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic      [7:0]        pixel_index_o,
  output logic      [9:0]        pixel_column_o,
  output logic      [8:0]        pixel_row_o,
  output logic                   run_last_o,
  output logic                   row_end_o,
  output logic                   image_end_o
);

  logic [9:0] last_column_q;
  logic [8:0] last_row_q;
  logic       cfg_wr;

  cmd_t front_cmd, fifo_cmd;
  logic front_push, fifo_full, fifo_empty, fifo_pop, take;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_column_q <= 10'd0;
      last_row_q    <= 9'd0;
    end else if (cfg_wr) begin
      case (paddr)
        ADDR_LAST_COLUMN: last_column_q <= pwdata[9:0];
        ADDR_LAST_ROW:    last_row_q    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_LAST_COLUMN: prdata = {22'd0, last_column_q};
      ADDR_LAST_ROW:    prdata = {23'd0, last_row_q};
      default:          prdata = 32'd0;
    endcase
  end

  assign full_o = fifo_full;
  assign take   = push_i && !fifo_full;

  pcx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .code_byte_i (code_byte_i),
    .cmd_o       (front_cmd),
    .cmd_push_o  (front_push)
  );

  pcx_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_cmd),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  pcx_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .last_column_i  (last_column_q),
    .last_row_i     (last_row_q),
    .cmd_i          (fifo_cmd),
    .cmd_empty_i    (fifo_empty),
    .cmd_pop_o      (fifo_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .pixel_index_o  (pixel_index_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .run_last_o     (run_last_o),
    .row_end_o      (row_end_o),
    .image_end_o    (image_end_o)
  );

  // nothing follows the final pixel
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && image_end_o) |=> empty_o)
    else $error("pixel emitted after picture end");

  a_end_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && image_end_o) |-> (row_end_o && run_last_o))
    else $error("picture end without row end and run end");

  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && row_end_o) |-> run_last_o)
    else $error("run continues past row end");

endmodule

`default_nettype wire
